// ===== design/efa_pkg.sv =====
// efa_pkg: shared constants, coefficient values and payload types for the
// error function pipeline. Used by every module in this folder; depends on
// nothing else.
package efa_pkg;

  // argument and result formats
  localparam int ARG_W    = 16;
  localparam int ARG_FRAC = ARG_W - 4;
  localparam int RES_FRAC = 16;
  localparam int OUT_W    = RES_FRAC + 2;

  // inner fixed point format, unsigned Q.30
  localparam int QB = 30;
  localparam logic [31:0] QONE  = 32'h4000_0000;
  localparam logic [31:0] QHALF = 32'h2000_0000;

  // argument magnitude clamp, 3.75
  localparam logic [31:0] X_MAX = 32'hF000_0000;

  // divisor that turns plain mode into a scaled division: |x| << 18 = (|x| << 30) / 4096
  localparam logic [15:0] PLAIN_DIV = 16'(1 << ARG_FRAC);

  // pipeline depths
  localparam int DIV_STAGES   = 16;
  localparam int POLY_STEPS   = 5;
  localparam int TAYLOR_TERMS = 12;

  // coefficient magnitudes, decimal values rounded to nearest in Q.30
  localparam longint unsigned A1_Q  = ((64'd254829592 << 30) + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned A2_Q  = ((64'd284496736 << 30) + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned A3_Q  = ((64'd1421413741 << 30) + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned A4_Q  = ((64'd1453152027 << 30) + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned A5_Q  = ((64'd1061405429 << 30) + 64'd500000000) / 64'd1000000000;
  localparam longint unsigned P_Q   = ((64'd3275911 << 30) + 64'd5000000) / 64'd10000000;
  localparam longint unsigned LN2_Q = ((64'd693147181 << 30) + 64'd500000000) / 64'd1000000000;

  localparam logic signed [31:0] C_A1 = 32'(A1_Q);
  localparam logic signed [31:0] C_A2 = -(32'(A2_Q));
  localparam logic signed [31:0] C_A3 = 32'(A3_Q);
  localparam logic signed [31:0] C_A4 = -(32'(A4_Q));
  localparam logic signed [31:0] C_A5 = 32'(A5_Q);
  localparam logic [29:0] C_P   = 30'(P_Q);
  localparam logic [29:0] C_LN2 = 30'(LN2_Q);

  // term added after each Horner multiply, none after the last
  localparam logic signed [31:0] POLY_ADD [POLY_STEPS] = '{C_A4, C_A3, C_A2, C_A1, 32'sd0};

  // per request flags and argument carried down the pipeline
  typedef struct packed {
    logic        neg;
    logic        inval;
    logic        force_one;
    logic        sat;
    logic [31:0] xm;
  } efa_tag_t;

endpackage

// ===== design/efa_div.sv =====
// efa_div: pipelined restoring divider, two quotient bits per stage, 32 bits.
// Carries an efa_tag_t alongside each request. Depends on efa_pkg.
module efa_div (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  efa_pkg::efa_tag_t in_tag,
  input  logic [31:0]      in_divisor,
  input  logic [31:0]      in_rem,
  input  logic [31:0]      in_low,
  output logic             out_valid,
  output efa_pkg::efa_tag_t out_tag,
  output logic [31:0]      out_quo
);

  logic              valid_r [efa_pkg::DIV_STAGES];
  efa_pkg::efa_tag_t tag_r   [efa_pkg::DIV_STAGES];
  logic [31:0]       div_r   [efa_pkg::DIV_STAGES];
  logic [31:0]       rem_r   [efa_pkg::DIV_STAGES];
  logic [31:0]       low_r   [efa_pkg::DIV_STAGES];
  logic [31:0]       quo_r   [efa_pkg::DIV_STAGES];

  for (genvar j = 0; j < efa_pkg::DIV_STAGES; j++) begin : g_stage
    logic              v_i;
    efa_pkg::efa_tag_t tag_i;
    logic [31:0]       div_i, rem_i, low_i, quo_i;
    logic [32:0]       r0, r0s, r1, r1s;
    logic              q_hi, q_lo;
    logic [31:0]       rem_nxt, quo_nxt;

    if (j == 0) begin : g_first
      assign v_i   = in_valid;
      assign tag_i = in_tag;
      assign div_i = in_divisor;
      assign rem_i = in_rem;
      assign low_i = in_low;
      assign quo_i = '0;
    end else begin : g_next
      assign v_i   = valid_r[j-1];
      assign tag_i = tag_r[j-1];
      assign div_i = div_r[j-1];
      assign rem_i = rem_r[j-1];
      assign low_i = low_r[j-1];
      assign quo_i = quo_r[j-1];
    end

    // two compare and subtract steps
    always_comb begin
      r0      = {rem_i, low_i[31]};
      q_hi    = (r0 >= {1'b0, div_i});
      r0s     = q_hi ? (r0 - {1'b0, div_i}) : r0;
      r1      = {r0s[31:0], low_i[30]};
      q_lo    = (r1 >= {1'b0, div_i});
      r1s     = q_lo ? (r1 - {1'b0, div_i}) : r1;
      rem_nxt = r1s[31:0];
      quo_nxt = {quo_i[29:0], q_hi, q_lo};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[j] <= 1'b0;
      end else if (en) begin
        valid_r[j] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tag_r[j] <= tag_i;
        div_r[j] <= div_i;
        rem_r[j] <= rem_nxt;
        low_r[j] <= {low_i[29:0], 2'b00};
        quo_r[j] <= quo_nxt;
      end
    end
  end

  assign out_valid = valid_r[efa_pkg::DIV_STAGES-1];
  assign out_tag   = tag_r[efa_pkg::DIV_STAGES-1];
  assign out_quo   = quo_r[efa_pkg::DIV_STAGES-1];

endmodule

// ===== design/efa_poly.sv =====
// efa_poly: Horner evaluation of t * (a1 + a2 t + ... + a5 t^4) in Q.30,
// a multiply stage and a round and add stage per term. Depends on efa_pkg.
module efa_poly (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  efa_pkg::efa_tag_t  in_tag,
  input  logic [30:0]        in_t,
  output logic               out_valid,
  output efa_pkg::efa_tag_t  out_tag,
  output logic signed [31:0] out_acc
);

  localparam int NS = efa_pkg::POLY_STEPS;

  logic               mv_r   [NS];
  efa_pkg::efa_tag_t  mtag_r [NS];
  logic [30:0]        mt_r   [NS];
  logic               mneg_r [NS];
  logic [61:0]        mp_r   [NS];
  logic               av_r   [NS];
  efa_pkg::efa_tag_t  atag_r [NS];
  logic [30:0]        at_r   [NS];
  logic signed [31:0] acc_r  [NS];

  for (genvar k = 0; k < NS; k++) begin : g_step
    logic               v_i;
    efa_pkg::efa_tag_t  tag_i;
    logic [30:0]        t_i;
    logic signed [31:0] acc_i;
    logic [31:0]        mag;
    logic [31:0]        m;
    logic signed [31:0] sm;

    if (k == 0) begin : g_first
      assign v_i   = in_valid;
      assign tag_i = in_tag;
      assign t_i   = in_t;
      assign acc_i = efa_pkg::C_A5;
    end else begin : g_next
      assign v_i   = av_r[k-1];
      assign tag_i = atag_r[k-1];
      assign t_i   = at_r[k-1];
      assign acc_i = acc_r[k-1];
    end

    // magnitude of the accumulator, sign kept aside
    assign mag = acc_i[31] ? (~acc_i + 32'd1) : acc_i;

    // rounded product, sign restored, next coefficient added
    always_comb begin
      m  = 32'((mp_r[k] + 62'(efa_pkg::QHALF)) >> efa_pkg::QB);
      sm = mneg_r[k] ? -m : m;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        mv_r[k] <= 1'b0;
        av_r[k] <= 1'b0;
      end else if (en) begin
        mv_r[k] <= v_i;
        av_r[k] <= mv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mtag_r[k] <= tag_i;
        mt_r[k]   <= t_i;
        mneg_r[k] <= acc_i[31];
        mp_r[k]   <= mag[30:0] * t_i;
        atag_r[k] <= mtag_r[k];
        at_r[k]   <= mt_r[k];
        acc_r[k]  <= sm + efa_pkg::POLY_ADD[k];
      end
    end
  end

  assign out_valid = av_r[NS-1];
  assign out_tag   = atag_r[NS-1];
  assign out_acc   = acc_r[NS-1];

endmodule

// ===== design/efa_exp.sv =====
// efa_exp: exp(-x^2) in Q.30. Squares the argument, splits off whole
// multiples of ln2, runs a 12 term Horner Taylor series and shifts. Uses efa_pkg.
module efa_exp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  efa_pkg::efa_tag_t  in_tag,
  input  logic signed [31:0] in_acc,
  output logic               out_valid,
  output efa_pkg::efa_tag_t  out_tag,
  output logic signed [31:0] out_acc,
  output logic [30:0]        out_e
);

  localparam int NT = efa_pkg::TAYLOR_TERMS;

  typedef struct packed {
    efa_pkg::efa_tag_t  tag;
    logic signed [31:0] acc;
    logic [29:0]        r;
    logic [4:0]         k;
  } carry_t;

  // squaring and range reduction stages
  logic        v0_r, v1_r, v2_r, v3_r;
  carry_t      c0_r, c1_r, c2_r, c3_r;
  logic [63:0] zp_r;
  logic [33:0] z_r;
  logic [33:0] red_r;
  logic [33:0] red_a, red_b;
  logic [4:0]  k_a, k_b;
  carry_t      c_in;

  assign c_in = '{tag: in_tag, acc: in_acc, r: '0, k: '0};

  // quotient bits four to two of z / ln2
  always_comb begin
    red_a = z_r;
    k_a   = '0;
    for (int b = 4; b >= 2; b--) begin
      if (red_a >= (34'(efa_pkg::C_LN2) << b)) begin
        red_a  = red_a - (34'(efa_pkg::C_LN2) << b);
        k_a[b] = 1'b1;
      end
    end
  end

  // quotient bits one and zero
  always_comb begin
    red_b = red_r;
    k_b   = c2_r.k;
    for (int b = 1; b >= 0; b--) begin
      if (red_b >= (34'(efa_pkg::C_LN2) << b)) begin
        red_b  = red_b - (34'(efa_pkg::C_LN2) << b);
        k_b[b] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c0_r  <= c_in;
      zp_r  <= in_tag.xm * in_tag.xm;
      c1_r  <= c0_r;
      z_r   <= 34'((zp_r + 64'(efa_pkg::QHALF)) >> efa_pkg::QB);
      c2_r  <= '{tag: c1_r.tag, acc: c1_r.acc, r: '0, k: k_a};
      red_r <= red_a;
      c3_r  <= '{tag: c2_r.tag, acc: c2_r.acc, r: red_b[29:0], k: k_b};
    end
  end

  // Taylor series, three stages per term
  logic        pv_r [NT];
  carry_t      pc_r [NT];
  logic [60:0] pp_r [NT];
  logic        qv_r [NT];
  carry_t      qc_r [NT];
  logic [30:0] qval_r [NT];
  logic [30:0] qest_r [NT];
  logic        sv_r [NT];
  carry_t      sc_r [NT];
  logic [30:0] s_r  [NT];

  for (genvar i = 0; i < NT; i++) begin : g_term
    localparam logic [3:0]  N     = 4'(NT - i);
    localparam logic [32:0] RECIP = 33'((64'd1 << 32) / (NT - i));

    logic        v_i;
    carry_t      c_i;
    logic [30:0] s_i;
    logic [30:0] p, val;
    logic [63:0] est;
    logic [34:0] back;
    logic [30:0] fix;
    logic [30:0] quo;

    if (i == 0) begin : g_first
      assign v_i = v3_r;
      assign c_i = c3_r;
      assign s_i = 31'(efa_pkg::QONE);
    end else begin : g_next
      assign v_i = sv_r[i-1];
      assign c_i = sc_r[i-1];
      assign s_i = s_r[i-1];
    end

    // round the product and add half the divisor, then estimate the quotient
    always_comb begin
      p   = 31'((pp_r[i] + 61'(efa_pkg::QHALF)) >> efa_pkg::QB);
      val = p + 31'(N >> 1);
      est = 64'(val) * 64'(RECIP);
    end

    // estimate is at most one low
    always_comb begin
      back = 35'(qval_r[i]) - 35'(qest_r[i]) * 35'(N);
      fix  = (back >= 35'(N)) ? 31'd1 : 31'd0;
      quo  = qest_r[i] + fix;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        pv_r[i] <= 1'b0;
        qv_r[i] <= 1'b0;
        sv_r[i] <= 1'b0;
      end else if (en) begin
        pv_r[i] <= v_i;
        qv_r[i] <= pv_r[i];
        sv_r[i] <= qv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pc_r[i]   <= c_i;
        pp_r[i]   <= c_i.r * s_i;
        qc_r[i]   <= pc_r[i];
        qval_r[i] <= val;
        qest_r[i] <= 31'(est >> 32);
        sc_r[i]   <= qc_r[i];
        s_r[i]    <= 31'(efa_pkg::QONE) - quo;
      end
    end
  end

  // scale by 2^-k with rounding
  logic        ev_r;
  carry_t      ec_r;
  logic [30:0] e_r;
  logic [30:0] rnd;
  logic [4:0]  k_l;

  assign k_l = sc_r[NT-1].k;
  assign rnd = (k_l == 5'd0) ? 31'd0 : (31'd1 << (k_l - 5'd1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r <= 1'b0;
    end else if (en) begin
      ev_r <= sv_r[NT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ec_r <= sc_r[NT-1];
      e_r  <= (s_r[NT-1] + rnd) >> k_l;
    end
  end

  assign out_valid = ev_r;
  assign out_tag   = ec_r.tag;
  assign out_acc   = ec_r.acc;
  assign out_e     = e_r;

endmodule

// ===== design/error_function_approx.sv =====
// error_function_approx: top level of the fixed point error function pipeline.
// Instantiates efa_div, efa_poly and efa_exp; uses efa_pkg.
//
// Usage
//   in_action selects erf(in_numerator) (0) or erf(in_numerator/in_denominator)
//   (1). Operands are signed Q3.12, out_erf_value is signed Q1.16. In ratio
//   mode a zero divisor gives +1 or -1 with the sign of the numerator, and a
//   zero over zero gives 0 with out_invalid set.
//   Both channels use valid and stall; a request moves on a rising edge with
//   valid high and stall low.
//   One request is taken every cycle while in_stall is low; the rate is set
//   by the single global advance of the 88 stage pipeline ahead of the
//   output register (input register, two 16 stage dividers, three argument
//   stages, a 10 stage Horner unit, a 41 stage exponential unit and a
//   product stage).
//   A two entry output buffer (output register plus skid) keeps accepting
//   while one result waits; in_stall rises only once the skid entry is full,
//   and then the whole pipeline holds until out_stall drops.
//   Reset (rst_n low, synchronous) clears all valid bits and both output
//   entries; no result is pending afterwards.
module error_function_approx (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_action,
  input  logic signed [15:0] in_numerator,
  input  logic signed [15:0] in_denominator,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [17:0] out_erf_value,
  output logic               out_invalid
);

  logic en;
  logic skid_valid_r;

  assign en       = !skid_valid_r;
  assign in_stall = skid_valid_r;

  // operand decode
  logic [15:0] num_u, den_u, ma, mb, mb_eff;
  logic        na, nb;
  logic        sat;
  efa_pkg::efa_tag_t tag_in;

  assign num_u  = in_numerator;
  assign den_u  = in_denominator;
  assign na     = num_u[15];
  assign nb     = den_u[15];
  assign ma     = na ? (~num_u + 16'd1) : num_u;
  assign mb     = nb ? (~den_u + 16'd1) : den_u;
  assign mb_eff = in_action ? mb : efa_pkg::PLAIN_DIV;
  assign sat    = ({4'b0, ma} << 2) > (({4'b0, mb_eff} << 4) - {4'b0, mb_eff});

  always_comb begin
    tag_in = '{neg: na, inval: 1'b0, force_one: 1'b0, sat: sat, xm: '0};
    if (in_action) begin
      if (mb == 16'd0) begin
        tag_in.inval     = (ma == 16'd0);
        tag_in.force_one = (ma != 16'd0);
        tag_in.neg       = na && (ma != 16'd0);
      end else begin
        tag_in.neg = na ^ nb;
      end
    end
  end

  // input register
  logic              s0_valid_r;
  efa_pkg::efa_tag_t s0_tag_r;
  logic [31:0]       s0_div_r, s0_rem_r, s0_low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_tag_r <= tag_in;
      s0_div_r <= 32'(mb_eff);
      s0_rem_r <= 32'(ma >> 2);
      s0_low_r <= {ma[1:0], 30'b0};
    end
  end

  // argument quotient
  logic              d1_valid;
  efa_pkg::efa_tag_t d1_tag;
  logic [31:0]       d1_quo;

  efa_div u_arg_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (s0_valid_r),
    .in_tag     (s0_tag_r),
    .in_divisor (s0_div_r),
    .in_rem     (s0_rem_r),
    .in_low     (s0_low_r),
    .out_valid  (d1_valid),
    .out_tag    (d1_tag),
    .out_quo    (d1_quo)
  );

  // clamp, p*x, then t denominator
  logic              s1_valid_r, s2_valid_r, s3_valid_r;
  efa_pkg::efa_tag_t s1_tag_r, s2_tag_r, s3_tag_r;
  logic [61:0]       s2_prod_r;
  logic [31:0]       s3_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= d1_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_tag_r    <= '{neg: d1_tag.neg, inval: d1_tag.inval,
                       force_one: d1_tag.force_one, sat: d1_tag.sat,
                       xm: d1_tag.sat ? efa_pkg::X_MAX : d1_quo};
      s2_tag_r    <= s1_tag_r;
      s2_prod_r   <= s1_tag_r.xm * efa_pkg::C_P;
      s3_tag_r    <= s2_tag_r;
      s3_den_r    <= efa_pkg::QONE
                     + 32'((s2_prod_r + 62'(efa_pkg::QHALF)) >> efa_pkg::QB);
    end
  end

  // t = 1 / (1 + p x), rounded
  logic              d2_valid;
  efa_pkg::efa_tag_t d2_tag;
  logic [31:0]       d2_quo;

  efa_div u_t_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (s3_valid_r),
    .in_tag     (s3_tag_r),
    .in_divisor (s3_den_r),
    .in_rem     (32'h1000_0000),
    .in_low     ({1'b0, s3_den_r[31:1]}),
    .out_valid  (d2_valid),
    .out_tag    (d2_tag),
    .out_quo    (d2_quo)
  );

  // polynomial in t
  logic               p_valid;
  efa_pkg::efa_tag_t  p_tag;
  logic signed [31:0] p_acc;

  efa_poly u_poly (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (d2_valid),
    .in_tag    (d2_tag),
    .in_t      (d2_quo[30:0]),
    .out_valid (p_valid),
    .out_tag   (p_tag),
    .out_acc   (p_acc)
  );

  // exp(-x^2)
  logic               x_valid;
  efa_pkg::efa_tag_t  x_tag;
  logic signed [31:0] x_acc;
  logic [30:0]        x_e;

  efa_exp u_exp (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p_valid),
    .in_tag    (p_tag),
    .in_acc    (p_acc),
    .out_valid (x_valid),
    .out_tag   (x_tag),
    .out_acc   (x_acc),
    .out_e     (x_e)
  );

  // poly * exp product
  logic              f1_valid_r;
  efa_pkg::efa_tag_t f1_tag_r;
  logic              f1_neg_r;
  logic [61:0]       f1_prod_r;
  logic [31:0]       acc_mag;

  assign acc_mag = x_acc[31] ? (~x_acc + 32'd1) : x_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (en) begin
      f1_valid_r <= x_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_tag_r  <= x_tag;
      f1_neg_r  <= x_acc[31];
      f1_prod_r <= acc_mag[30:0] * x_e;
    end
  end

  // 1 - product, clamp, round to Q1.16, special cases, sign
  logic [31:0] m;
  logic [31:0] y;
  logic [16:0] r16, res_mag;
  logic [17:0] res_val;

  always_comb begin
    m = 32'((f1_prod_r + 62'(efa_pkg::QHALF)) >> efa_pkg::QB);
    if (f1_neg_r) begin
      y = efa_pkg::QONE;
    end else if (m > efa_pkg::QONE) begin
      y = '0;
    end else begin
      y = efa_pkg::QONE - m;
    end
    r16 = 17'((y + 32'(1 << (efa_pkg::QB - efa_pkg::RES_FRAC - 1)))
              >> (efa_pkg::QB - efa_pkg::RES_FRAC));
    if (f1_tag_r.inval) begin
      res_mag = '0;
    end else if (f1_tag_r.force_one) begin
      res_mag = 17'(1 << efa_pkg::RES_FRAC);
    end else begin
      res_mag = r16;
    end
    res_val = f1_tag_r.neg ? (~{1'b0, res_mag} + 18'd1) : {1'b0, res_mag};
  end

  // output register and skid entry
  logic        out_valid_r;
  logic [17:0] out_val_r, skid_val_r;
  logic        out_inv_r, skid_inv_r;
  logic        out_take;

  assign out_take = out_valid_r && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (en) begin
      if (out_valid_r && !out_take) begin
        skid_valid_r <= f1_valid_r;
      end else begin
        out_valid_r <= f1_valid_r;
      end
    end else if (out_take) begin
      skid_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (out_valid_r && !out_take) begin
        skid_val_r <= res_val;
        skid_inv_r <= f1_tag_r.inval;
      end else begin
        out_val_r <= res_val;
        out_inv_r <= f1_tag_r.inval;
      end
    end else if (out_take) begin
      out_val_r <= skid_val_r;
      out_inv_r <= skid_inv_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_erf_value = out_val_r;
  assign out_invalid   = out_inv_r;

  // checks
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without an output entry");

  a_skid_on_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && out_stall))
    else $error("skid entry filled while output was free");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_invalid) |-> (out_erf_value == 18'sd0))
    else $error("invalid result carries a nonzero value");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_erf_value >= -18'sd65536 && out_erf_value <= 18'sd65536))
    else $error("result outside [-1, 1]");

endmodule
